FILE: rtl/pwcs_pkg.sv
package pwcs_pkg;

	typedef enum logic [1:0] {
		MODE_WRITE   = 2'd0,
		MODE_TIMER   = 2'd1,
		MODE_QUARTER = 2'd2,
		MODE_HALF    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_CONTROL = 2'd0,
		REG_SWEEP   = 2'd1,
		REG_PER_LO  = 2'd2,
		REG_PER_HI  = 2'd3
	} reg_sel_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  reg_index;
		logic [7:0]  write_data;
	} item_t;

	typedef struct packed {
		logic [3:0]  sample;
		logic        length_active;
		logic        sweep_muting;
	} result_t;

	// Channel state seen by the result stage (period travels on its own port).
	typedef struct packed {
		logic [1:0]  duty_select;
		logic [2:0]  step_position;
		logic        constant_flag;
		logic [3:0]  volume_level;
		logic [3:0]  decay_level;
		logic        length_nonzero;
		logic        sweep_down;
		logic [2:0]  sweep_amount;
	} chan_view_t;

	localparam logic [3:0] ENV_MAX = 4'hF;
	localparam logic [2:0] MUTE_MIN_PERIOD_MSB = 3'd3; // period below 8 mutes
	localparam int unsigned PER_HI_WIDTH = 11;

	function automatic logic [7:0] length_lookup(input logic [4:0] idx);
		logic [7:0] v;
		case (idx)
			5'd0:  v = 8'd10;
			5'd1:  v = 8'd254;
			5'd2:  v = 8'd20;
			5'd3:  v = 8'd2;
			5'd4:  v = 8'd40;
			5'd5:  v = 8'd4;
			5'd6:  v = 8'd80;
			5'd7:  v = 8'd6;
			5'd8:  v = 8'd160;
			5'd9:  v = 8'd8;
			5'd10: v = 8'd60;
			5'd11: v = 8'd10;
			5'd12: v = 8'd14;
			5'd13: v = 8'd12;
			5'd14: v = 8'd26;
			5'd15: v = 8'd14;
			5'd16: v = 8'd12;
			5'd17: v = 8'd16;
			5'd18: v = 8'd24;
			5'd19: v = 8'd18;
			5'd20: v = 8'd48;
			5'd21: v = 8'd20;
			5'd22: v = 8'd96;
			5'd23: v = 8'd22;
			5'd24: v = 8'd192;
			5'd25: v = 8'd24;
			5'd26: v = 8'd72;
			5'd27: v = 8'd26;
			5'd28: v = 8'd16;
			5'd29: v = 8'd28;
			5'd30: v = 8'd32;
			default: v = 8'd30;
		endcase
		return v;
	endfunction

	function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
		logic [7:0] row;
		case (sel)
			2'd0: row = 8'b0000_0010;
			2'd1: row = 8'b0000_0110;
			2'd2: row = 8'b0001_1110;
			default: row = 8'b1111_1001;
		endcase
		return row[step];
	endfunction

endpackage

FILE: rtl/pwcs_sweep.sv
module pwcs_sweep
	import pwcs_pkg::*;
#(
	parameter int unsigned PERIOD_WIDTH = 11
) (
	input  logic [PERIOD_WIDTH-1:0] period,
	input  logic [2:0]              amount,
	input  logic                    down,
	input  logic                    extra_one,
	output logic [PERIOD_WIDTH-1:0] target,
	output logic                    mute
);

	logic [PERIOD_WIDTH-1:0] change;
	logic [PERIOD_WIDTH:0]   sum;
	logic [PERIOD_WIDTH:0]   sub;
	logic [PERIOD_WIDTH:0]   per_ext;
	logic [PERIOD_WIDTH:0]   diff;

	always_comb begin
		change  = period >> amount;
		per_ext = {1'b0, period};
		sum     = per_ext + {1'b0, change};
		sub     = {1'b0, change} + {{PERIOD_WIDTH{1'b0}}, extra_one};
		// clamp at zero when the change plus the extra one exceeds the period
		diff    = (sub > per_ext) ? '0 : (per_ext - sub);
		target  = down ? diff[PERIOD_WIDTH-1:0] : sum[PERIOD_WIDTH-1:0];
		mute    = (period[PERIOD_WIDTH-1:MUTE_MIN_PERIOD_MSB] == '0) || (!down && sum[PERIOD_WIDTH]);
	end

endmodule

FILE: rtl/pwcs_core.sv
module pwcs_core
	import pwcs_pkg::*;
#(
	parameter int unsigned PERIOD_WIDTH = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  item_t                   item,
	input  logic                    extra_one,
	output chan_view_t              view,
	output logic [PERIOD_WIDTH-1:0] period
);

	logic [1:0]              duty_q, duty_n;
	logic                    const_q, const_n;
	logic [3:0]              vol_q, vol_n;
	logic                    halt_q, halt_n;
	logic                    swp_on_q, swp_on_n;
	logic [2:0]              swp_rate_q, swp_rate_n;
	logic                    swp_down_q, swp_down_n;
	logic [2:0]              swp_amt_q, swp_amt_n;
	logic                    swp_reload_q, swp_reload_n;
	logic [2:0]              swp_cnt_q, swp_cnt_n;
	logic [PERIOD_WIDTH-1:0] per_q, per_n;
	logic [PERIOD_WIDTH-1:0] per_cnt_q, per_cnt_n;
	logic [2:0]              step_q, step_n;
	logic [7:0]              len_q, len_n;
	logic                    env_start_q, env_start_n;
	logic [3:0]              env_cnt_q, env_cnt_n;
	logic [3:0]              decay_q, decay_n;

	logic [PERIOD_WIDTH-1:0]  swp_target;
	logic                     swp_mute;
	logic [PER_HI_WIDTH-1:0]  per_hi_val;

	pwcs_sweep #(.PERIOD_WIDTH(PERIOD_WIDTH)) u_sweep (
		.period    (per_q),
		.amount    (swp_amt_q),
		.down      (swp_down_q),
		.extra_one (extra_one),
		.target    (swp_target),
		.mute      (swp_mute)
	);

	always_comb begin
		duty_n       = duty_q;
		const_n      = const_q;
		vol_n        = vol_q;
		halt_n       = halt_q;
		swp_on_n     = swp_on_q;
		swp_rate_n   = swp_rate_q;
		swp_down_n   = swp_down_q;
		swp_amt_n    = swp_amt_q;
		swp_reload_n = swp_reload_q;
		swp_cnt_n    = swp_cnt_q;
		per_n        = per_q;
		per_cnt_n    = per_cnt_q;
		step_n       = step_q;
		len_n        = len_q;
		env_start_n  = env_start_q;
		env_cnt_n    = env_cnt_q;
		decay_n      = decay_q;
		per_hi_val   = {item.write_data[2:0], per_q[7:0]};

		case (item.mode)
			MODE_WRITE: begin
				case (reg_sel_t'(item.reg_index))
					REG_CONTROL: begin
						vol_n   = item.write_data[3:0];
						const_n = item.write_data[4];
						halt_n  = item.write_data[5];
						duty_n  = item.write_data[7:6];
					end
					REG_SWEEP: begin
						swp_amt_n    = item.write_data[2:0];
						swp_down_n   = item.write_data[3];
						swp_rate_n   = item.write_data[6:4];
						swp_on_n     = item.write_data[7];
						swp_reload_n = 1'b1;
					end
					REG_PER_LO: begin
						per_n[7:0] = item.write_data;
					end
					default: begin
						// upper period bits beyond the register are cleared
						len_n       = length_lookup(item.write_data[7:3]);
						per_n       = PERIOD_WIDTH'(per_hi_val);
						per_cnt_n   = PERIOD_WIDTH'(per_hi_val);
						step_n      = '0;
						env_start_n = 1'b1;
					end
				endcase
			end
			MODE_TIMER: begin
				if (per_cnt_q == '0) begin
					per_cnt_n = per_q;
					step_n    = step_q + 3'd1;
				end else begin
					per_cnt_n = per_cnt_q - PERIOD_WIDTH'(1);
				end
			end
			MODE_QUARTER: begin
				if (env_start_q) begin
					env_start_n = 1'b0;
					decay_n     = ENV_MAX;
					env_cnt_n   = vol_q;
				end else if (env_cnt_q != '0) begin
					env_cnt_n = env_cnt_q - 4'd1;
				end else begin
					env_cnt_n = vol_q;
					if (decay_q != '0)
						decay_n = decay_q - 4'd1;
					else if (halt_q)
						decay_n = ENV_MAX;
				end
			end
			default: begin
				if (len_q != '0 && !halt_q)
					len_n = len_q - 8'd1;
				if (swp_cnt_q == '0 && swp_on_q && swp_amt_q != '0 && !swp_mute)
					per_n = swp_target;
				if (swp_cnt_q == '0 || swp_reload_q) begin
					swp_cnt_n    = swp_rate_q;
					swp_reload_n = 1'b0;
				end else begin
					swp_cnt_n = swp_cnt_q - 3'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q       <= '0;
			const_q      <= 1'b0;
			vol_q        <= '0;
			halt_q       <= 1'b0;
			swp_on_q     <= 1'b0;
			swp_rate_q   <= '0;
			swp_down_q   <= 1'b0;
			swp_amt_q    <= '0;
			swp_reload_q <= 1'b0;
			swp_cnt_q    <= '0;
			per_q        <= '0;
			per_cnt_q    <= '0;
			step_q       <= '0;
			len_q        <= '0;
			env_start_q  <= 1'b0;
			env_cnt_q    <= '0;
			decay_q      <= '0;
		end else if (advance) begin
			duty_q       <= duty_n;
			const_q      <= const_n;
			vol_q        <= vol_n;
			halt_q       <= halt_n;
			swp_on_q     <= swp_on_n;
			swp_rate_q   <= swp_rate_n;
			swp_down_q   <= swp_down_n;
			swp_amt_q    <= swp_amt_n;
			swp_reload_q <= swp_reload_n;
			swp_cnt_q    <= swp_cnt_n;
			per_q        <= per_n;
			per_cnt_q    <= per_cnt_n;
			step_q       <= step_n;
			len_q        <= len_n;
			env_start_q  <= env_start_n;
			env_cnt_q    <= env_cnt_n;
			decay_q      <= decay_n;
		end
	end

	always_comb begin
		view.duty_select    = duty_q;
		view.step_position  = step_q;
		view.constant_flag  = const_q;
		view.volume_level   = vol_q;
		view.decay_level    = decay_q;
		view.length_nonzero = (len_q != '0);
		view.sweep_down     = swp_down_q;
		view.sweep_amount   = swp_amt_q;
		period              = per_q;
	end

endmodule

FILE: rtl/pwcs_result.sv
module pwcs_result
	import pwcs_pkg::*;
#(
	parameter int unsigned PERIOD_WIDTH = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  chan_view_t              view,
	input  logic [PERIOD_WIDTH-1:0] period,
	input  logic                    extra_one,
	output logic                    pend_s1,
	output logic                    result_valid,
	input  logic                    result_ready,
	output result_t                 result
);

	logic                    pend_q;
	logic                    out_valid_q;
	result_t                 out_q;
	result_t                 res_n;
	logic                    move;
	logic                    mute;
	logic [PERIOD_WIDTH-1:0] unused_target;

	pwcs_sweep #(.PERIOD_WIDTH(PERIOD_WIDTH)) u_sweep (
		.period    (period),
		.amount    (view.sweep_amount),
		.down      (view.sweep_down),
		.extra_one (extra_one),
		.target    (unused_target),
		.mute      (mute)
	);

	always_comb begin
		res_n.sample        = '0;
		res_n.length_active = view.length_nonzero;
		res_n.sweep_muting  = mute;
		if (view.length_nonzero && !mute && duty_bit(view.duty_select, view.step_position))
			res_n.sample = view.constant_flag ? view.volume_level : view.decay_level;
		if (unused_target == '0)
			res_n.sweep_muting = mute;
	end

	// state already reflects the pending item; move it to the output register
	assign move       = pend_q && (!out_valid_q || result_ready);
	assign item_ready = !pend_q || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				pend_q <= 1'b1;
			else if (move)
				pend_q <= 1'b0;
			if (move)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move)
			out_q <= res_n;
	end

	assign pend_s1      = pend_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

FILE: rtl/pulse_wave_channel_sweep.sv
// A result passes through the state update (pending stage), then the result
// register.
// Throughput: one item per cycle; the input stalls only when both the pending
// stage and the result register are full and the result is not taken.
// Reset (arst_n low, asynchronous): all channel state, the negate option and both
// valid flags clear to zero.
module pulse_wave_channel_sweep
	import pwcs_pkg::*;
#(
	parameter int unsigned PERIOD_WIDTH = 11
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  logic    cfg_data
);

	logic                    extra_one_q;
	logic                    advance;
	logic                    pend_s1;
	chan_view_t              view;
	logic [PERIOD_WIDTH-1:0] period;

	assign cfg_ready = 1'b1;
	assign advance   = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			extra_one_q <= 1'b0;
		else if (cfg_valid && cfg_ready)
			extra_one_q <= cfg_data;
	end

	pwcs_core #(.PERIOD_WIDTH(PERIOD_WIDTH)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item),
		.extra_one (extra_one_q),
		.view      (view),
		.period    (period)
	);

	pwcs_result #(.PERIOD_WIDTH(PERIOD_WIDTH)) u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.view         (view),
		.period       (period),
		.extra_one    (extra_one_q),
		.pend_s1      (pend_s1),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> pend_s1)
		else $error("item transfer did not fill the pending stage");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && pend_s1 && result_valid && !result_ready))
		else $error("item accepted while pending result had nowhere to go");

	a_sample_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.sample != '0) |-> (result.length_active && !result.sweep_muting))
		else $error("nonzero sample while length is zero or sweep mutes");

endmodule

FILE: sim/pulse_wave_channel_sweep_tb.sv
`timescale 1ns / 100ps

module pulse_wave_channel_sweep_tb
	import pwcs_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned RANDOM_ITEMS = 1100;

	localparam logic [7:0] LEN_LOAD [0:31] = '{
		8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
		8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
		8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
		8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
	};
	// bit n of a row is the output at sequencer step n
	localparam logic [7:0] DUTY_WAVE [0:3] = '{
		8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001
	};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic    cfg_data = 1'b0;

	// expected channel state
	logic [1:0]  m_duty = '0;
	logic        m_const = 1'b0;
	logic [3:0]  m_vol = '0;
	logic        m_loop = 1'b0;
	logic        m_sw_en = 1'b0;
	logic [2:0]  m_sw_rate = '0;
	logic        m_sw_neg = 1'b0;
	logic [2:0]  m_sw_shift = '0;
	logic        m_sw_reload = 1'b0;
	logic [2:0]  m_sw_div = '0;
	logic [10:0] m_period = '0;
	logic [10:0] m_timer = '0;
	logic [2:0]  m_step = '0;
	logic [7:0]  m_len = '0;
	logic        m_env_start = 1'b0;
	logic [3:0]  m_env_div = '0;
	logic [3:0]  m_decay = '0;
	logic        m_neg_plus_one = 1'b0;

	result_t     expected_levels[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit          src_gaps_on = 1'b1;
	bit          sink_stalls_on = 1'b1;
	int unsigned sink_hold = 0;

	pulse_wave_channel_sweep i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [11:0] sweep_goal();
		logic [11:0] delta;
		logic [11:0] sub;
		delta = {1'b0, m_period} >> m_sw_shift;
		if (!m_sw_neg)
			return {1'b0, m_period} + delta;
		sub = delta + {11'd0, m_neg_plus_one};
		return (sub > {1'b0, m_period}) ? 12'd0 : {1'b0, m_period} - sub;
	endfunction

	function automatic logic sweep_mutes();
		return (m_period < 11'd8) || (sweep_goal() > 12'h7FF);
	endfunction

	// apply one transferred item to the expected state and queue its result
	task automatic channel_advance(input item_t it);
		result_t     want;
		logic [11:0] goal;
		logic        muted;
		logic [7:0]  d;
		d = it.write_data;
		case (it.mode)
			MODE_WRITE: begin
				case (reg_sel_t'(it.reg_index))
					REG_CONTROL: begin
						m_vol = d[3:0];
						m_const = d[4];
						m_loop = d[5];
						m_duty = d[7:6];
					end
					REG_SWEEP: begin
						m_sw_shift = d[2:0];
						m_sw_neg = d[3];
						m_sw_rate = d[6:4];
						m_sw_en = d[7];
						m_sw_reload = 1'b1;
					end
					REG_PER_LO: m_period[7:0] = d;
					default: begin
						m_len = LEN_LOAD[d[7:3]];
						m_period[10:8] = d[2:0];
						m_timer = m_period;
						m_step = '0;
						m_env_start = 1'b1;
					end
				endcase
			end
			MODE_TIMER: begin
				if (m_timer == 0) begin
					m_timer = m_period;
					m_step = m_step + 3'd1;
				end else begin
					m_timer = m_timer - 11'd1;
				end
			end
			MODE_QUARTER: begin
				if (m_env_start) begin
					m_env_start = 1'b0;
					m_decay = 4'hF;
					m_env_div = m_vol;
				end else if (m_env_div != 0) begin
					m_env_div = m_env_div - 4'd1;
				end else begin
					m_env_div = m_vol;
					if (m_decay != 0)
						m_decay = m_decay - 4'd1;
					else if (m_loop)
						m_decay = 4'hF;
				end
			end
			default: begin
				if (m_len != 0 && !m_loop)
					m_len = m_len - 8'd1;
				if (m_sw_div == 0 && m_sw_en && m_sw_shift != 0 && !sweep_mutes()) begin
					goal = sweep_goal();
					m_period = goal[10:0];
				end
				if (m_sw_div == 0 || m_sw_reload) begin
					m_sw_div = m_sw_rate;
					m_sw_reload = 1'b0;
				end else begin
					m_sw_div = m_sw_div - 3'd1;
				end
			end
		endcase
		muted = sweep_mutes();
		want.sample = (m_len != 0 && !muted && DUTY_WAVE[m_duty][m_step]) ?
			(m_const ? m_vol : m_decay) : 4'd0;
		want.length_active = (m_len != 0);
		want.sweep_muting = muted;
		expected_levels.push_back(want);
	endtask

	// call at a rising edge; valid stays high after the transfer
	task automatic send_item(input item_t it);
		int unsigned gap;
		gap = src_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		channel_advance(it);
	endtask

	function automatic item_t make_item(input mode_t m, input reg_sel_t r,
			input logic [7:0] d);
		item_t it;
		it.mode = m;
		it.reg_index = r;
		it.write_data = d;
		return it;
	endfunction

	task automatic send_write(input reg_sel_t r, input logic [7:0] d);
		send_item(make_item(MODE_WRITE, r, d));
	endtask

	task automatic send_tick(input mode_t m);
		send_item(make_item(m, reg_sel_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
	endtask

	function automatic item_t random_item();
		item_t       it;
		int unsigned r;
		it.reg_index = 2'($urandom_range(0, 3));
		it.write_data = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 20)
			it.mode = MODE_WRITE;
		else if (r < 65)
			it.mode = MODE_TIMER;
		else if (r < 80)
			it.mode = MODE_QUARTER;
		else
			it.mode = MODE_HALF;
		// keep periods short most of the time so the sequencer moves
		if (it.mode == MODE_WRITE) begin
			case (reg_sel_t'(it.reg_index))
				REG_PER_HI: if ($urandom_range(0, 3) != 0) it.write_data[2:0] = 3'd0;
				REG_PER_LO: if ($urandom_range(0, 1) != 0) it.write_data = 8'($urandom_range(8, 40));
				default: ;
			endcase
		end
		return it;
	endfunction

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_levels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_option(input logic v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		m_neg_plus_one = v;
		@(posedge clk);
	endtask

	task automatic test_basic_ops();
		send_write(REG_CONTROL, 8'h3F);
		// period 0 at the high write leaves the timer at zero
		send_write(REG_PER_HI, 8'h08);
		send_write(REG_PER_LO, 8'h08);
		send_tick(MODE_TIMER);
		send_tick(MODE_TIMER);
		send_tick(MODE_HALF);
		send_tick(MODE_QUARTER);
		send_write(REG_CONTROL, 8'hC0);
		send_tick(MODE_QUARTER);
		send_write(REG_CONTROL, 8'hD5);
		send_tick(MODE_HALF);
	endtask

	task automatic test_sweep_cases();
		send_write(REG_SWEEP, 8'h88);
		send_tick(MODE_HALF);
		send_write(REG_PER_LO, 8'hFF);
		send_write(REG_PER_HI, 8'h07);
		send_write(REG_SWEEP, 8'h81);
		send_write(REG_SWEEP, 8'hFF);
		send_tick(MODE_HALF);
		write_option(1'b1);
		// shift 0 with the extra one would take the target below zero, so it clamps at zero
		send_write(REG_SWEEP, 8'h88);
		send_tick(MODE_HALF);
		send_write(REG_SWEEP, 8'h8A);
		send_tick(MODE_HALF);
		send_tick(MODE_TIMER);
		write_option(1'b0);
	endtask

	task automatic test_backpressure();
		sink_hold = 80;
		src_gaps_on = 1'b0;
		repeat (40) send_item(random_item());
		src_gaps_on = 1'b1;
		drain();
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 4; p++) begin
			write_option(p[0]);
			for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
				if (n % 50 == 0) begin
					src_gaps_on = ($urandom_range(0, 2) != 0);
					sink_stalls_on = ($urandom_range(0, 2) != 0);
				end
				send_item(random_item());
			end
		end
		src_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
	endtask

	initial begin : result_sink
		int unsigned n;
		@(posedge clk);
		forever begin
			if (sink_hold > 0) begin
				n = sink_hold;
				sink_hold = 0;
				result_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				n = $urandom_range(1, 12);
				for (int k = 0; k < n; k++) begin
					@(posedge clk);
					if (sink_hold > 0)
						break;
				end
			end
		end
	end

	always @(posedge clk) begin : sample_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_levels.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = expected_levels.pop_front();
				if (result.sample !== want.sample)
					report_mismatch($sformatf("sample got %0d want %0d",
						result.sample, want.sample));
				if (result.length_active !== want.length_active)
					report_mismatch($sformatf("length_active got %0b want %0b",
						result.length_active, want.length_active));
				if (result.sweep_muting !== want.sweep_muting)
					report_mismatch($sformatf("sweep_muting got %0b want %0b",
						result.sweep_muting, want.sweep_muting));
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_sweep_cases();
		test_backpressure();
		test_random_phases();
		drain();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/pwcs_pkg.sv
rtl/pwcs_sweep.sv
rtl/pwcs_core.sv
rtl/pwcs_result.sv
rtl/pulse_wave_channel_sweep.sv
sim/pulse_wave_channel_sweep_tb.sv
